/* rtl/bpc_pkg.sv */
package bpc_pkg;

    localparam int RAW_W     = 24;
    localparam int FIX_W     = 32;
    localparam int FRAC      = 30;
    localparam int DIVX_W    = RAW_W + 3;
    localparam int RECIP_W   = 28;
    localparam int PROD_W    = DIVX_W + RECIP_W;
    localparam int RECIP_SH  = 31;
    localparam int MAG_Q_W   = 31;
    localparam int T_W       = 21;
    localparam int P_W       = 32;
    localparam int WIDE_W    = 64;
    localparam int ACC_W     = 56;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // ceil(2^31 / 15), exact floor(x / 15) for x below 2^27
    localparam logic [RECIP_W-1:0] SCALE_RECIP = 28'd143165577;

    typedef enum logic [2:0] {
        REG_TEMP_COEFS   = 3'd0,
        REG_PRESS_OFFSET = 3'd1,
        REG_PRESS_LIN    = 3'd2,
        REG_TEMP_CROSS   = 3'd3,
        REG_CROSS_LIN    = 3'd4,
        REG_PRESS_QUAD   = 3'd5,
        REG_CROSS_QUAD   = 3'd6,
        REG_PRESS_CUBIC  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [11:0] c0;
        logic signed [11:0] c1;
        logic signed [19:0] c00;
        logic signed [19:0] c10;
        logic signed [15:0] c01;
        logic signed [15:0] c11;
        logic signed [15:0] c20;
        logic signed [15:0] c21;
        logic signed [15:0] c30;
    } coef_t;

    typedef struct packed {
        logic                    ok;
        logic signed [FIX_W-1:0] ps;
        logic signed [FIX_W-1:0] ts;
    } scaled_t;

endpackage

/* rtl/bpc_if.sv */
interface bpc_sample_if;
    import bpc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [RAW_W-1:0] raw_pressure;
    logic signed [RAW_W-1:0] raw_temperature;
    logic                    pressure_ready;
    logic                    temperature_ready;

    modport source (
        output valid, raw_pressure, raw_temperature, pressure_ready, temperature_ready,
        input  ready
    );
    modport sink (
        input  valid, raw_pressure, raw_temperature, pressure_ready, temperature_ready,
        output ready
    );
endinterface

interface bpc_result_if;
    import bpc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  valid_res;
    logic signed [T_W-1:0] temperature;
    logic signed [P_W-1:0] pressure;

    modport source (
        output valid, valid_res, temperature, pressure,
        input  ready
    );
    modport sink (
        input  valid, valid_res, temperature, pressure,
        output ready
    );
endinterface

/* rtl/bpc_regs.sv */
module bpc_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0] paddr,
    input  logic [bpc_pkg::DATA_W-1:0] pwdata,
    output logic [bpc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output bpc_pkg::coef_t             coef
);
    import bpc_pkg::*;

    coef_t    coef_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign coef   = coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_TEMP_COEFS:
                begin
                    coef_reg.c0 <= pwdata[23:12];
                    coef_reg.c1 <= pwdata[11:0];
                end
                REG_PRESS_OFFSET: coef_reg.c00 <= pwdata[19:0];
                REG_PRESS_LIN:    coef_reg.c10 <= pwdata[19:0];
                REG_TEMP_CROSS:   coef_reg.c01 <= pwdata[15:0];
                REG_CROSS_LIN:    coef_reg.c11 <= pwdata[15:0];
                REG_PRESS_QUAD:   coef_reg.c20 <= pwdata[15:0];
                REG_CROSS_QUAD:   coef_reg.c21 <= pwdata[15:0];
                REG_PRESS_CUBIC:  coef_reg.c30 <= pwdata[15:0];
                default:          coef_reg <= coef_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TEMP_COEFS:   prdata = {8'd0, coef_reg.c0, coef_reg.c1};
            REG_PRESS_OFFSET: prdata = {12'd0, coef_reg.c00};
            REG_PRESS_LIN:    prdata = {12'd0, coef_reg.c10};
            REG_TEMP_CROSS:   prdata = {16'd0, coef_reg.c01};
            REG_CROSS_LIN:    prdata = {16'd0, coef_reg.c11};
            REG_PRESS_QUAD:   prdata = {16'd0, coef_reg.c20};
            REG_CROSS_QUAD:   prdata = {16'd0, coef_reg.c21};
            REG_PRESS_CUBIC:  prdata = {16'd0, coef_reg.c30};
            default:          prdata = '0;
        endcase
    end

endmodule

/* rtl/bpc_scale.sv */
module bpc_scale (
    input  logic              clk,
    input  logic              rst_n,
    bpc_sample_if.sink        sample,
    output logic              mid_valid,
    input  logic              mid_ready,
    output bpc_pkg::scaled_t  mid_data
);
    import bpc_pkg::*;

    logic [1:0] v_reg;
    logic [2:0] en;

    // stage 1: magnitude times reciprocal of 15
    logic [RAW_W-1:0]  mag_p_next, mag_t_next;
    logic [PROD_W-1:0] prod_p_next, prod_t_next;
    logic [RAW_W-1:0]  mag_p_reg, mag_t_reg;
    logic [PROD_W-1:0] prod_p_reg, prod_t_reg;
    logic              neg_p_reg, neg_t_reg, ok1_reg;

    // stage 2: 2048/15 = 136 + 8/15
    logic [MAG_Q_W-1:0] q_p, q_t;
    scaled_t            out_next, out_reg;

    always_comb
    begin
        en[2] = mid_ready;
        en[1] = !v_reg[1] || en[2];
        en[0] = !v_reg[0] || en[1];
    end

    assign sample.ready = en[0];
    assign mid_valid    = v_reg[1];
    assign mid_data     = out_reg;

    assign mag_p_next  = sample.raw_pressure[RAW_W-1] ?
                         RAW_W'(-sample.raw_pressure) : RAW_W'(sample.raw_pressure);
    assign mag_t_next  = sample.raw_temperature[RAW_W-1] ?
                         RAW_W'(-sample.raw_temperature) : RAW_W'(sample.raw_temperature);
    assign prod_p_next = PROD_W'({mag_p_next, 3'b111}) * PROD_W'(SCALE_RECIP);
    assign prod_t_next = PROD_W'({mag_t_next, 3'b111}) * PROD_W'(SCALE_RECIP);

    assign q_p = MAG_Q_W'({mag_p_reg, 7'd0}) + MAG_Q_W'({mag_p_reg, 3'd0})
               + MAG_Q_W'(prod_p_reg[PROD_W-1:RECIP_SH]);
    assign q_t = MAG_Q_W'({mag_t_reg, 7'd0}) + MAG_Q_W'({mag_t_reg, 3'd0})
               + MAG_Q_W'(prod_t_reg[PROD_W-1:RECIP_SH]);

    always_comb
    begin
        out_next.ok = ok1_reg;
        out_next.ps = neg_p_reg ? -$signed({1'b0, q_p}) : $signed({1'b0, q_p});
        out_next.ts = neg_t_reg ? -$signed({1'b0, q_t}) : $signed({1'b0, q_t});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= sample.valid;
            end
            if (en[1])
            begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mag_p_reg  <= mag_p_next;
            mag_t_reg  <= mag_t_next;
            prod_p_reg <= prod_p_next;
            prod_t_reg <= prod_t_next;
            neg_p_reg  <= sample.raw_pressure[RAW_W-1];
            neg_t_reg  <= sample.raw_temperature[RAW_W-1];
            ok1_reg    <= sample.pressure_ready && sample.temperature_ready;
        end
        if (en[1])
        begin
            out_reg <= out_next;
        end
    end

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (&v_reg))
        else $error("scale stage stalls input with a free slot");

endmodule

/* rtl/bpc_poly.sv */
module bpc_poly (
    input  logic              clk,
    input  logic              rst_n,
    input  bpc_pkg::coef_t    coef,
    input  logic              mid_valid,
    output logic              mid_ready,
    input  bpc_pkg::scaled_t  mid_data,
    bpc_result_if.source      result
);
    import bpc_pkg::*;

    localparam int NSTG  = 7;
    localparam int TC1_W = 44;
    localparam int LIN_W = 52;
    localparam int CRS_W = 48;
    localparam int TSH_W = TC1_W - 22;
    localparam int TSUM_W = 23;
    localparam logic signed [WIDE_W-1:0] HALF30 = WIDE_W'(64'sd536870912);
    localparam logic signed [TC1_W-1:0]  HALF22 = TC1_W'(44'sd2097152);
    localparam logic signed [ACC_W-1:0]  HALF24 = ACC_W'(56'sd8388608);
    localparam logic signed [TSUM_W-1:0] T_MAX  = TSUM_W'(23'sd1048575);
    localparam logic signed [TSUM_W-1:0] T_MIN  = -TSUM_W'(23'sd1048576);

    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   en;

    logic signed [11:0] c0, c1;
    logic signed [19:0] c00, c10;
    logic signed [15:0] c01, c11, c20, c21, c30;

    assign c0  = coef.c0;
    assign c1  = coef.c1;
    assign c00 = coef.c00;
    assign c10 = coef.c10;
    assign c01 = coef.c01;
    assign c11 = coef.c11;
    assign c20 = coef.c20;
    assign c21 = coef.c21;
    assign c30 = coef.c30;

    // stage 3: first products
    logic signed [FIX_W-1:0]  ps3_reg;
    logic signed [WIDE_W-1:0] pp3_reg, tpm3_reg;
    logic signed [TC1_W-1:0]  tc13_reg;
    logic signed [LIN_W-1:0]  lin3_reg;
    logic signed [CRS_W-1:0]  tcr3_reg;
    logic                     ok3_reg;

    // stage 4: back to q30, temperature, linear sum
    logic signed [WIDE_W-1:0] pp_rnd, tpm_rnd;
    logic signed [TC1_W-1:0]  tc1_rnd;
    logic signed [TSH_W-1:0]  tsh;
    logic signed [18:0]       c0x;
    logic signed [TSUM_W-1:0] t_full;
    logic signed [T_W-1:0]    t_next;
    logic signed [ACC_W-1:0]  a_next;
    logic signed [FIX_W-1:0]  ps4_reg, p24_reg, tp4_reg;
    logic signed [T_W-1:0]    t4_reg;
    logic signed [ACC_W-1:0]  a4_reg;
    logic                     ok4_reg;

    // stage 5: cubic and cross products
    logic signed [WIDE_W-1:0] p3m5_reg, tp2m5_reg;
    logic signed [CRS_W-1:0]  q205_reg, q115_reg;
    logic signed [ACC_W-1:0]  a5_reg;
    logic signed [T_W-1:0]    t5_reg;
    logic                     ok5_reg;

    // stage 6
    logic signed [WIDE_W-1:0] p3m_rnd, tp2m_rnd;
    logic signed [FIX_W-1:0]  p36_reg, tp26_reg;
    logic signed [ACC_W-1:0]  b6_reg;
    logic signed [T_W-1:0]    t6_reg;
    logic                     ok6_reg;

    // stage 7
    logic signed [CRS_W-1:0]  q307_reg, q217_reg;
    logic signed [ACC_W-1:0]  b7_reg;
    logic signed [T_W-1:0]    t7_reg;
    logic                     ok7_reg;

    // stage 8
    logic signed [ACC_W-1:0]  acc8_reg;
    logic signed [T_W-1:0]    t8_reg;
    logic                     ok8_reg;

    // stage 9: output register
    logic signed [ACC_W-1:0]  acc_rnd;
    logic                     ok9_reg;
    logic signed [T_W-1:0]    t9_reg;
    logic signed [P_W-1:0]    p9_reg;

    always_comb
    begin
        en[NSTG] = result.ready;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign mid_ready          = en[0];
    assign result.valid       = v_reg[NSTG-1];
    assign result.valid_res   = ok9_reg;
    assign result.temperature = t9_reg;
    assign result.pressure    = p9_reg;

    assign pp_rnd  = pp3_reg + HALF30;
    assign tpm_rnd = tpm3_reg + HALF30;
    assign tc1_rnd = tc13_reg + HALF22;
    assign tsh     = tc1_rnd[TC1_W-1:22];
    assign c0x     = {c0, 7'd0};
    assign t_full  = TSUM_W'(c0x) + TSUM_W'(tsh);
    assign a_next  = (ACC_W'(c00) <<< FRAC) + ACC_W'(lin3_reg) + ACC_W'(tcr3_reg);

    always_comb
    begin
        if (t_full > T_MAX)
        begin
            t_next = T_MAX[T_W-1:0];
        end
        else if (t_full < T_MIN)
        begin
            t_next = T_MIN[T_W-1:0];
        end
        else
        begin
            t_next = t_full[T_W-1:0];
        end
    end

    assign p3m_rnd  = p3m5_reg + HALF30;
    assign tp2m_rnd = tp2m5_reg + HALF30;
    // 56-bit sum shifted by 24 fits 32 bits, the pressure clamp is implied
    assign acc_rnd  = acc8_reg + HALF24;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= mid_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ps3_reg  <= mid_data.ps;
            pp3_reg  <= mid_data.ps * mid_data.ps;
            tpm3_reg <= mid_data.ts * mid_data.ps;
            tc13_reg <= c1 * mid_data.ts;
            lin3_reg <= c10 * mid_data.ps;
            tcr3_reg <= c01 * mid_data.ts;
            ok3_reg  <= mid_data.ok;
        end
        if (en[1])
        begin
            ps4_reg <= ps3_reg;
            p24_reg <= pp_rnd[FRAC+FIX_W-1:FRAC];
            tp4_reg <= tpm_rnd[FRAC+FIX_W-1:FRAC];
            t4_reg  <= t_next;
            a4_reg  <= a_next;
            ok4_reg <= ok3_reg;
        end
        if (en[2])
        begin
            p3m5_reg  <= p24_reg * ps4_reg;
            tp2m5_reg <= tp4_reg * ps4_reg;
            q205_reg  <= c20 * p24_reg;
            q115_reg  <= c11 * tp4_reg;
            a5_reg    <= a4_reg;
            t5_reg    <= t4_reg;
            ok5_reg   <= ok4_reg;
        end
        if (en[3])
        begin
            p36_reg  <= p3m_rnd[FRAC+FIX_W-1:FRAC];
            tp26_reg <= tp2m_rnd[FRAC+FIX_W-1:FRAC];
            b6_reg   <= a5_reg + ACC_W'(q205_reg) + ACC_W'(q115_reg);
            t6_reg   <= t5_reg;
            ok6_reg  <= ok5_reg;
        end
        if (en[4])
        begin
            q307_reg <= c30 * p36_reg;
            q217_reg <= c21 * tp26_reg;
            b7_reg   <= b6_reg;
            t7_reg   <= t6_reg;
            ok7_reg  <= ok6_reg;
        end
        if (en[5])
        begin
            acc8_reg <= b7_reg + ACC_W'(q307_reg) + ACC_W'(q217_reg);
            t8_reg   <= t7_reg;
            ok8_reg  <= ok7_reg;
        end
        if (en[6])
        begin
            ok9_reg <= ok8_reg;
            t9_reg  <= ok8_reg ? t8_reg : '0;
            p9_reg  <= ok8_reg ? acc_rnd[ACC_W-1:ACC_W-P_W] : '0;
        end
    end

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid && mid_ready |=> v_reg[0])
        else $error("accepted request not captured in first stage");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !mid_ready |-> (&v_reg))
        else $error("pipeline stalls with an empty stage");

    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.valid_res |->
            (result.temperature == '0) && (result.pressure == '0))
        else $error("result without both readings is not zeroed");

endmodule

/* rtl/baro_pressure_temp_compensation.sv */
// throughput: one sample per cycle; a stall at the result side backs up through the stages
// the rate is set by the nine-stage multiply pipeline, at most one multiplier deep per stage
// reset: rst_n clears all stage valid bits and all calibration registers to zero
module baro_pressure_temp_compensation (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0] paddr,
    input  logic [bpc_pkg::DATA_W-1:0] pwdata,
    output logic [bpc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    bpc_sample_if.sink                 sample,
    bpc_result_if.source               result
);
    import bpc_pkg::*;

    coef_t   coef;
    scaled_t mid_data;
    logic    mid_valid;
    logic    mid_ready;

    bpc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    bpc_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid_data  (mid_data)
    );

    bpc_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid_data  (mid_data),
        .result    (result)
    );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import bpc_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 100;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_pressure;
        logic signed [RAW_W-1:0] raw_temperature;
        logic                    pressure_ready;
        logic                    temperature_ready;
    } sample_t;

    typedef struct packed {
        logic                  valid_res;
        logic signed [T_W-1:0] temperature;
        logic signed [P_W-1:0] pressure;
    } reading_t;

    class compensation_check;
        reading_t expected_readings[$];
        int       errors;
        // calibration coefficients, sign extended
        longint   t_offset, t_slope, p_const, p_lin, t_lin, x_lin, p_sq, x_sq, p_cube;

        function new();
            errors   = 0;
            t_offset = 0;
            t_slope  = 0;
            p_const  = 0;
            p_lin    = 0;
            t_lin    = 0;
            x_lin    = 0;
            p_sq     = 0;
            x_sq     = 0;
            p_cube   = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] d);
            case (idx)
                REG_TEMP_COEFS:
                begin
                    t_offset = longint'($signed(d[23:12]));
                    t_slope  = longint'($signed(d[11:0]));
                end
                REG_PRESS_OFFSET: p_const = longint'($signed(d[19:0]));
                REG_PRESS_LIN:    p_lin   = longint'($signed(d[19:0]));
                REG_TEMP_CROSS:   t_lin   = longint'($signed(d[15:0]));
                REG_CROSS_LIN:    x_lin   = longint'($signed(d[15:0]));
                REG_PRESS_QUAD:   p_sq    = longint'($signed(d[15:0]));
                REG_CROSS_QUAD:   x_sq    = longint'($signed(d[15:0]));
                REG_PRESS_CUBIC:  p_cube  = longint'($signed(d[15:0]));
                default: ;
            endcase
        endfunction

        // add half an lsb, then floor
        function longint rnd_shift(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        // raw / 7864320 in q30 is raw * 2048 / 15, nearest
        function longint to_q30(longint raw);
            longint n;
            n = raw * 2048;
            if (n >= 0)
                return (n + 7) / 15;
            return -((-n + 7) / 15);
        endfunction

        function reading_t compensate(sample_t s);
            reading_t r;
            longint   ps, ts, p2, p3, tp, tp2, t, acc, p;
            r = '0;
            if (!(s.pressure_ready && s.temperature_ready))
                return r;
            ps  = to_q30(longint'($signed(s.raw_pressure)));
            ts  = to_q30(longint'($signed(s.raw_temperature)));
            t   = t_offset * 128 + rnd_shift(t_slope * ts, 22);
            if (t > 1048575)
                t = 1048575;
            if (t < -1048576)
                t = -1048576;
            p2  = rnd_shift(ps * ps, 30);
            p3  = rnd_shift(p2 * ps, 30);
            tp  = rnd_shift(ts * ps, 30);
            tp2 = rnd_shift(tp * ps, 30);
            acc = p_const * (longint'(1) <<< 30) + p_lin * ps + p_sq * p2 + p_cube * p3
                + t_lin * ts + x_lin * tp + x_sq * tp2;
            p   = rnd_shift(acc, 24);
            if (p > 64'sd2147483647)
                p = 64'sd2147483647;
            if (p < -64'sd2147483648)
                p = -64'sd2147483648;
            r.valid_res   = 1'b1;
            r.temperature = t[T_W-1:0];
            r.pressure    = p[P_W-1:0];
            return r;
        endfunction

        function void note_sample(sample_t s);
            expected_readings.push_back(compensate(s));
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (expected_readings.size() == 0)
            begin
                $display("%0t: unexpected result valid_res=%0d temperature=%0d pressure=%0d",
                         $time, got.valid_res, got.temperature, got.pressure);
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            if (got.valid_res !== want.valid_res)
            begin
                $display("%0t: valid_res expected %0d got %0d",
                         $time, want.valid_res, got.valid_res);
                errors++;
            end
            if (got.temperature !== want.temperature)
            begin
                $display("%0t: temperature expected %0d got %0d",
                         $time, want.temperature, got.temperature);
                errors++;
            end
            if (got.pressure !== want.pressure)
            begin
                $display("%0t: pressure expected %0d got %0d",
                         $time, want.pressure, got.pressure);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    bpc_sample_if sample_bus ();
    bpc_result_if result_bus ();

    compensation_check comp;
    bit                sender_quiet = 1'b0;
    bit                hold_req     = 1'b0;
    bit                hold_off     = 1'b0;
    int                cycle_count  = 0;

    baro_pressure_temp_compensation u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_bus.sink),
        .result  (result_bus.source)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAIL baro_pressure_temp_compensation");
            $finish;
        end
    end

    // long output stall so the pipeline fills and backs up into the input
    initial
    begin
        wait (hold_req);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // result side
    initial
    begin
        int       stall;
        int       quiet_left;
        bit       quiet;
        reading_t got;
        result_bus.ready = 1'b0;
        quiet_left = 0;
        quiet = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (quiet_left == 0)
            begin
                quiet_left = $urandom_range(10, 40);
                quiet = ($urandom_range(0, 3) == 0);
            end
            quiet_left--;
            stall = quiet ? 0 : $urandom_range(0, 11);
            repeat (stall)
            begin
                @(negedge clk);
                result_bus.ready = 1'b0;
            end
            @(negedge clk);
            while (hold_off)
            begin
                result_bus.ready = 1'b0;
                @(negedge clk);
            end
            result_bus.ready = 1'b1;
            do @(posedge clk); while (!result_bus.valid);
            got.valid_res   = result_bus.valid_res;
            got.temperature = result_bus.temperature;
            got.pressure    = result_bus.pressure;
            comp.check_reading(got);
        end
    end

    function automatic int reg_bits(reg_idx_t idx);
        case (idx) inside
            REG_TEMP_COEFS:                  return 24;
            REG_PRESS_OFFSET, REG_PRESS_LIN: return 20;
            default:                         return 16;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] extreme_value(reg_idx_t idx, bit hi);
        int w;
        w = reg_bits(idx);
        if (idx == REG_TEMP_COEFS)
            return hi ? 32'h007F_F7FF : 32'h0080_0800;
        return hi ? (32'h1 << (w - 1)) - 32'h1 : 32'h1 << (w - 1);
    endfunction

    function automatic logic [DATA_W-1:0] random_value(reg_idx_t idx);
        int                w;
        logic [DATA_W-1:0] d;
        logic [DATA_W-1:0] junk;
        w = reg_bits(idx);
        case ($urandom_range(0, 5))
            0:       d = extreme_value(idx, 1'b1);
            1:       d = extreme_value(idx, 1'b0);
            2:       d = '0;
            3:       d = (32'h1 << w) - 32'h1;
            default: d = $urandom() & ((32'h1 << w) - 32'h1);
        endcase
        // bits above the register width must be dropped
        junk = $urandom();
        if ($urandom_range(0, 1) == 1)
            d = d | (junk << w);
        return d;
    endfunction

    function automatic logic [RAW_W-1:0] random_raw();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 9))
            0:       return 24'h7F_FFFF;
            1:       return 24'h80_0000;
            2:       return RAW_W'($urandom_range(0, 200) - 100);
            default: return w[RAW_W-1:0];
        endcase
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        s.raw_pressure    = random_raw();
        s.raw_temperature = random_raw();
        s.pressure_ready    = 1'b1;
        s.temperature_ready = 1'b1;
        if ($urandom_range(0, 7) == 0)
        begin
            s.pressure_ready    = 1'($urandom_range(0, 1));
            s.temperature_ready = 1'($urandom_range(0, 1));
        end
        return s;
    endfunction

    task automatic send_sample(sample_t s);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 11);
        repeat (gap)
        begin
            @(negedge clk);
            sample_bus.valid = 1'b0;
        end
        @(negedge clk);
        sample_bus.valid             = 1'b1;
        sample_bus.raw_pressure      = s.raw_pressure;
        sample_bus.raw_temperature   = s.raw_temperature;
        sample_bus.pressure_ready    = s.pressure_ready;
        sample_bus.temperature_ready = s.temperature_ready;
        do @(posedge clk); while (!sample_bus.ready);
        comp.note_sample(s);
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        @(negedge clk);
        sample_bus.valid = 1'b0;
        while (comp.pending() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(idx) << 2;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        comp.set_reg(idx, data);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic load_extremes(bit hi);
        drain();
        for (int r = 0; r < 8; r++)
            apb_write(reg_idx_t'(r), extreme_value(reg_idx_t'(r), hi));
    endtask

    task automatic load_random();
        drain();
        for (int r = 0; r < 8; r++)
            apb_write(reg_idx_t'(r), random_value(reg_idx_t'(r)));
    endtask

    // full-scale, zero and plus or minus one raw values, then each not-ready combination
    task automatic send_corner_samples(int n);
        int      p_pick[9] = '{0, 1, 0, 1, 2, 3, 0, 0, 1};
        int      t_pick[9] = '{0, 1, 1, 0, 2, 4, 0, 0, 1};
        bit [1:0] flags[9] = '{2'b11, 2'b11, 2'b11, 2'b11, 2'b11, 2'b11, 2'b01, 2'b10, 2'b00};
        logic [RAW_W-1:0] corner[5] = '{24'h7F_FFFF, 24'h80_0000, 24'h00_0000,
                                        24'hFF_FFFF, 24'h00_0001};
        sample_t s;
        for (int i = 0; i < n; i++)
        begin
            s.raw_pressure      = corner[p_pick[i]];
            s.raw_temperature   = corner[t_pick[i]];
            s.pressure_ready    = flags[i][1];
            s.temperature_ready = flags[i][0];
            send_sample(s);
        end
    endtask

    initial
    begin
        comp = new();
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        sample_bus.valid             = 1'b0;
        sample_bus.raw_pressure      = '0;
        sample_bus.raw_temperature   = '0;
        sample_bus.pressure_ready    = 1'b0;
        sample_bus.temperature_ready = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // coefficients still at their reset value
        send_corner_samples(3);
        load_extremes(1'b1);
        send_corner_samples(9);
        load_extremes(1'b0);
        send_corner_samples(9);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            load_random();
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 25 == 0)
                    sender_quiet = ($urandom_range(0, 3) == 0);
                if (phase == 2 && i == 10)
                begin
                    sender_quiet = 1'b1;
                    hold_req = 1'b1;
                end
                if (phase == 5 && i == 50)
                    drain();
                send_sample(random_sample());
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (comp.errors == 0)
            $display("PASS baro_pressure_temp_compensation");
        else
            $display("FAIL baro_pressure_temp_compensation");
        $finish;
    end

endmodule

/* sim.f */
rtl/bpc_pkg.sv
rtl/bpc_if.sv
rtl/bpc_regs.sv
rtl/bpc_scale.sv
rtl/bpc_poly.sv
rtl/baro_pressure_temp_compensation.sv
bench/testbench.sv
